@@ rtl/eig2x2_pkg.sv @@
// Shared widths, constants and pipeline sideband types for the 2x2 eigen unit.
// No dependencies.
package eig2x2_pkg;

    localparam int DATA_W = 32;
    localparam int TOL_W  = 31;
    localparam int MAG_W  = 33;
    localparam int NRM_W  = 31;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;
    localparam int NUM_W  = 62;
    localparam int DEN_W  = 32;
    localparam int QUO_W  = 31;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] h;
        logic                     row;
        logic                     off;
        logic                     cplx;
    } eig_disc_side_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]     lo;
        logic signed [DATA_W-1:0]     hi;
        logic                         sat;
        logic                         axes;
        logic [1:0]                   zero;
        logic [3:0]                   neg;
        logic [3:0][NRM_W-1:0]        mag;
    } eig_norm_side_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic                     sat;
        logic                     axes;
        logic [1:0]               zero;
        logic [3:0]               neg;
    } eig_div_side_t;

endpackage

@@ rtl/eig2x2_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, several lanes.
// Depends on eig2x2_pkg for default widths.
module eig2x2_sqrt_pipe
    import eig2x2_pkg::*;
#(
    parameter int IW    = RAD_W,
    parameter int LANES = 1,
    parameter int PW    = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [LANES-1:0][IW-1:0]   in_rad,
    input  logic [PW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][IW/2-1:0] out_root,
    output logic [PW-1:0]              out_side
);
    localparam int RW   = IW / 2;
    localparam int REMW = RW + 2;
    localparam int CW   = RW + 4;

    logic [RW-1:0]              valid_reg;
    logic [LANES-1:0][IW-1:0]   rad_reg  [RW];
    logic [LANES-1:0][REMW-1:0] rem_reg  [RW];
    logic [LANES-1:0][RW-1:0]   root_reg [RW];
    logic [PW-1:0]              side_reg [RW];

    genvar g;
    generate
        for (g = 0; g < RW; g++)
        begin : g_step
            logic                       valid_in;
            logic [LANES-1:0][IW-1:0]   rad_in;
            logic [LANES-1:0][REMW-1:0] rem_in;
            logic [LANES-1:0][RW-1:0]   root_in;
            logic [PW-1:0]              side_in;
            logic [LANES-1:0][IW-1:0]   rad_next;
            logic [LANES-1:0][REMW-1:0] rem_next;
            logic [LANES-1:0][RW-1:0]   root_next;

            if (g == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign rad_in   = in_rad;
                assign rem_in   = '0;
                assign root_in  = '0;
                assign side_in  = in_side;
            end
            else
            begin : g_rest
                assign valid_in = valid_reg[g-1];
                assign rad_in   = rad_reg[g-1];
                assign rem_in   = rem_reg[g-1];
                assign root_in  = root_reg[g-1];
                assign side_in  = side_reg[g-1];
            end

            always_comb
            begin : p_step
                logic [CW-1:0] cand;
                logic [CW-1:0] trial;
                cand  = '0;
                trial = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    cand        = {rem_in[l], rad_in[l][IW-1 -: 2]};
                    trial       = {2'b00, root_in[l], 2'b01};
                    rad_next[l] = rad_in[l] << 2;
                    if (cand >= trial)
                    begin
                        rem_next[l]  = REMW'(cand - trial);
                        root_next[l] = {root_in[l][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l]  = cand[REMW-1:0];
                        root_next[l] = {root_in[l][RW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else
                    valid_reg[g] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                rad_reg[g]  <= rad_next;
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                side_reg[g] <= side_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

@@ rtl/eig2x2_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Depends on eig2x2_pkg for default widths.
module eig2x2_div_pipe
    import eig2x2_pkg::*;
#(
    parameter int NW    = NUM_W,
    parameter int DW    = DEN_W,
    parameter int QW    = QUO_W,
    parameter int LANES = 1,
    parameter int PW    = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [LANES-1:0][NW-1:0] in_num,
    input  logic [LANES-1:0][DW-1:0] in_den,
    input  logic [PW-1:0]            in_side,
    output logic                     out_valid,
    output logic [LANES-1:0][QW-1:0] out_quo,
    output logic [PW-1:0]            out_side
);
    logic [QW-1:0]            valid_reg;
    logic [LANES-1:0][QW-1:0] low_reg [QW];
    logic [LANES-1:0][DW-1:0] rem_reg [QW];
    logic [LANES-1:0][DW-1:0] den_reg [QW];
    logic [LANES-1:0][QW-1:0] quo_reg [QW];
    logic [PW-1:0]            side_reg [QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_step
            logic                     valid_in;
            logic [LANES-1:0][QW-1:0] low_in;
            logic [LANES-1:0][DW-1:0] rem_in;
            logic [LANES-1:0][DW-1:0] den_in;
            logic [LANES-1:0][QW-1:0] quo_in;
            logic [PW-1:0]            side_in;
            logic [LANES-1:0][QW-1:0] low_next;
            logic [LANES-1:0][DW-1:0] rem_next;
            logic [LANES-1:0][QW-1:0] quo_next;

            if (g == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign den_in   = in_den;
                assign quo_in   = '0;
                assign side_in  = in_side;
                for (genvar l = 0; l < LANES; l++)
                begin : g_lane
                    assign low_in[l] = in_num[l][QW-1:0];
                    assign rem_in[l] = DW'(in_num[l] >> QW);
                end
            end
            else
            begin : g_rest
                assign valid_in = valid_reg[g-1];
                assign low_in   = low_reg[g-1];
                assign rem_in   = rem_reg[g-1];
                assign den_in   = den_reg[g-1];
                assign quo_in   = quo_reg[g-1];
                assign side_in  = side_reg[g-1];
            end

            always_comb
            begin : p_step
                logic [DW:0] cand;
                cand = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    cand        = {rem_in[l], low_in[l][QW-1]};
                    low_next[l] = low_in[l] << 1;
                    if (cand >= {1'b0, den_in[l]})
                    begin
                        rem_next[l] = DW'(cand - {1'b0, den_in[l]});
                        quo_next[l] = {quo_in[l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = cand[DW-1:0];
                        quo_next[l] = {quo_in[l][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else
                    valid_reg[g] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                low_reg[g]  <= low_next;
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= den_in;
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

@@ rtl/eigen_decomposition_2x2_unit.sv @@
// Top level of the closed-form 2x2 eigen decomposition pipeline.
// Depends on eig2x2_pkg, eig2x2_sqrt_pipe and eig2x2_div_pipe.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  config   | tolerance_we         | tolerance_wdata
//  item in  | start, busy          | top_left, top_right, bottom_left, bottom_right
//  item out | done (one cycle)     | eigenvalues, eigenvectors, complex_roots, saturated
//
// One item per clock; busy is always low.
// Between the accepting edge and the result strobe lie 32 root stages for the
// discriminant, 32 for the vector norms, 31 divider stages and 11 arithmetic stages.
// Reset clears every valid bit and the tolerance; results cannot be held off.
module eigen_decomposition_2x2_unit
    import eig2x2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tolerance_we,
    input  logic [TOL_W-1:0]         tolerance_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] top_left,
    input  logic signed [DATA_W-1:0] top_right,
    input  logic signed [DATA_W-1:0] bottom_left,
    input  logic signed [DATA_W-1:0] bottom_right,
    output logic                     done,
    output logic signed [DATA_W-1:0] small_eigenvalue,
    output logic signed [DATA_W-1:0] large_eigenvalue,
    output logic signed [DATA_W-1:0] first_vec_x,
    output logic signed [DATA_W-1:0] first_vec_y,
    output logic signed [DATA_W-1:0] second_vec_x,
    output logic signed [DATA_W-1:0] second_vec_y,
    output logic                     complex_roots,
    output logic                     saturated
);
    localparam int LAT = 3 + ROOT_W + 6 + ROOT_W + 1 + QUO_W + 1;

    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (tolerance_we)
            tol_reg <= tolerance_wdata;
    end

    assign busy = 1'b0;

    // stage 1
    logic [DATA_W:0]   sum1;
    logic [DATA_W:0]   diff1;
    logic [DATA_W-1:0] mb1;
    logic [DATA_W-1:0] mc1;
    logic              row1;
    eig_disc_side_t    side1_next;
    logic [MAG_W-1:0]  dm1_next;

    logic              s1_valid_reg;
    eig_disc_side_t    s1_side_reg;
    logic [MAG_W-1:0]  s1_dm_reg;

    always_comb
    begin
        sum1  = {top_left[DATA_W-1], top_left} + {bottom_right[DATA_W-1], bottom_right};
        diff1 = {top_left[DATA_W-1], top_left} - {bottom_right[DATA_W-1], bottom_right};
        mb1   = top_right[DATA_W-1] ? DATA_W'(-top_right) : top_right;
        mc1   = bottom_left[DATA_W-1] ? DATA_W'(-bottom_left) : bottom_left;
        row1  = mb1 > mc1;
        dm1_next        = diff1[DATA_W] ? MAG_W'(-diff1) : diff1;
        side1_next.a    = top_left;
        side1_next.b    = top_right;
        side1_next.c    = bottom_left;
        side1_next.d    = bottom_right;
        side1_next.h    = sum1[DATA_W:1];
        side1_next.row  = row1;
        side1_next.off  = (row1 ? mb1 : mc1) > {1'b0, tol_reg};
        side1_next.cplx = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= side1_next;
        s1_dm_reg   <= dm1_next;
    end

    // stage 2
    logic [2*MAG_W-1:0]     sq_full;
    logic signed [DATA_W-1:0] b2;
    logic signed [DATA_W-1:0] c2;
    logic signed [RAD_W-1:0]  bc_full;
    logic                   s2_valid_reg;
    eig_disc_side_t         s2_side_reg;
    logic [RAD_W-1:0]       s2_sq_reg;
    logic [RAD_W-1:0]       s2_bc_reg;

    assign sq_full = (2*MAG_W)'(s1_dm_reg) * (2*MAG_W)'(s1_dm_reg);
    assign b2      = s1_side_reg.b;
    assign c2      = s1_side_reg.c;
    assign bc_full = b2 * c2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s1_side_reg;
        s2_sq_reg   <= sq_full[RAD_W-1:0];
        s2_bc_reg   <= bc_full;
    end

    // stage 3
    logic [RAD_W:0]    disc3;
    eig_disc_side_t    side3_next;
    logic              s3_valid_reg;
    eig_disc_side_t    s3_side_reg;
    logic [RAD_W-1:0]  s3_rad_reg;

    always_comb
    begin
        disc3           = {3'b000, s2_sq_reg[RAD_W-1:2]} + {s2_bc_reg[RAD_W-1], s2_bc_reg};
        side3_next      = s2_side_reg;
        side3_next.cplx = disc3[RAD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= side3_next;
        s3_rad_reg  <= disc3[RAD_W] ? '0 : disc3[RAD_W-1:0];
    end

    // discriminant root
    logic [0:0][RAD_W-1:0]  rad_a;
    logic                   sa_valid;
    logic [0:0][ROOT_W-1:0] root_a;
    eig_disc_side_t         sa_side;

    assign rad_a[0] = s3_rad_reg;

    eig2x2_sqrt_pipe #(
        .IW    (RAD_W),
        .LANES (1),
        .PW    ($bits(eig_disc_side_t))
    ) u_disc_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rad    (rad_a),
        .in_side   (s3_side_reg),
        .out_valid (sa_valid),
        .out_root  (root_a),
        .out_side  (sa_side)
    );

    // stage 4: eigenvalues with clamp
    logic [DATA_W+1:0] h34;
    logic [DATA_W+1:0] r34;
    logic [DATA_W+1:0] lo34;
    logic [DATA_W+1:0] hi34;
    logic              lo_ovf;
    logic              hi_ovf;
    logic [DATA_W-1:0] lo4_next;
    logic [DATA_W-1:0] hi4_next;

    logic                     s4_valid_reg;
    logic signed [DATA_W-1:0] s4_lo_reg;
    logic signed [DATA_W-1:0] s4_hi_reg;
    logic                     s4_sat_reg;
    logic                     s4_axes_reg;
    logic                     s4_row_reg;
    logic [DATA_W-1:0]        s4_a_reg;
    logic [DATA_W-1:0]        s4_b_reg;
    logic [DATA_W-1:0]        s4_c_reg;
    logic [DATA_W-1:0]        s4_d_reg;

    always_comb
    begin
        h34    = {{2{sa_side.h[DATA_W-1]}}, sa_side.h};
        r34    = {2'b00, root_a[0]};
        lo34   = h34 - r34;
        hi34   = h34 + r34;
        lo_ovf = !((lo34[DATA_W+1:DATA_W-1] == 3'b000) || (lo34[DATA_W+1:DATA_W-1] == 3'b111));
        hi_ovf = !((hi34[DATA_W+1:DATA_W-1] == 3'b000) || (hi34[DATA_W+1:DATA_W-1] == 3'b111));
        if (lo_ovf)
            lo4_next = lo34[DATA_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            lo4_next = lo34[DATA_W-1:0];
        if (hi_ovf)
            hi4_next = hi34[DATA_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            hi4_next = hi34[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= sa_valid;
    end

    always_ff @(posedge clk)
    begin
        s4_lo_reg   <= lo4_next;
        s4_hi_reg   <= hi4_next;
        s4_sat_reg  <= lo_ovf || hi_ovf;
        s4_axes_reg <= sa_side.cplx || !sa_side.off;
        s4_row_reg  <= sa_side.row;
        s4_a_reg    <= sa_side.a;
        s4_b_reg    <= sa_side.b;
        s4_c_reg    <= sa_side.c;
        s4_d_reg    <= sa_side.d;
    end

    // stage 5: raw eigenvector components
    logic [MAG_W-1:0] comp5 [4];
    logic [MAG_W-1:0] lo_a5;
    logic [MAG_W-1:0] hi_a5;
    logic [MAG_W-1:0] lo_d5;
    logic [MAG_W-1:0] hi_d5;
    logic [MAG_W-1:0] b5;
    logic [MAG_W-1:0] c5;

    logic                     s5_valid_reg;
    logic [MAG_W-1:0]         s5_mag_reg [4];
    logic [3:0]               s5_neg_reg;
    logic signed [DATA_W-1:0] s5_lo_reg;
    logic signed [DATA_W-1:0] s5_hi_reg;
    logic                     s5_sat_reg;
    logic                     s5_axes_reg;

    always_comb
    begin
        b5    = {s4_b_reg[DATA_W-1], s4_b_reg};
        c5    = {s4_c_reg[DATA_W-1], s4_c_reg};
        lo_a5 = {s4_lo_reg[DATA_W-1], s4_lo_reg} - {s4_a_reg[DATA_W-1], s4_a_reg};
        hi_a5 = {s4_hi_reg[DATA_W-1], s4_hi_reg} - {s4_a_reg[DATA_W-1], s4_a_reg};
        lo_d5 = {s4_lo_reg[DATA_W-1], s4_lo_reg} - {s4_d_reg[DATA_W-1], s4_d_reg};
        hi_d5 = {s4_hi_reg[DATA_W-1], s4_hi_reg} - {s4_d_reg[DATA_W-1], s4_d_reg};
        if (s4_row_reg)
        begin
            comp5[0] = b5;
            comp5[1] = lo_a5;
            comp5[2] = b5;
            comp5[3] = hi_a5;
        end
        else
        begin
            comp5[0] = lo_d5;
            comp5[1] = c5;
            comp5[2] = hi_d5;
            comp5[3] = c5;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            s5_mag_reg[i] <= comp5[i][MAG_W-1] ? MAG_W'(-comp5[i]) : comp5[i];
            s5_neg_reg[i] <= comp5[i][MAG_W-1];
        end
        s5_lo_reg   <= s4_lo_reg;
        s5_hi_reg   <= s4_hi_reg;
        s5_sat_reg  <= s4_sat_reg;
        s5_axes_reg <= s4_axes_reg;
    end

    // stage 6: leading one of the larger magnitude
    logic [MAG_W-1:0] big6 [2];
    logic [5:0]       msb6 [2];

    logic                     s6_valid_reg;
    logic [MAG_W-1:0]         s6_mag_reg [4];
    logic [5:0]               s6_msb_reg [2];
    logic [1:0]               s6_zero_reg;
    logic [3:0]               s6_neg_reg;
    logic signed [DATA_W-1:0] s6_lo_reg;
    logic signed [DATA_W-1:0] s6_hi_reg;
    logic                     s6_sat_reg;
    logic                     s6_axes_reg;

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            big6[v] = (s5_mag_reg[2*v] > s5_mag_reg[2*v+1]) ? s5_mag_reg[2*v]
                                                              : s5_mag_reg[2*v+1];
            msb6[v] = '0;
            for (int i = 0; i < MAG_W; i++)
            begin
                if (big6[v][i])
                    msb6[v] = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
        begin
            s6_msb_reg[v]  <= msb6[v];
            s6_zero_reg[v] <= big6[v] == '0;
        end
        s6_mag_reg  <= s5_mag_reg;
        s6_neg_reg  <= s5_neg_reg;
        s6_lo_reg   <= s5_lo_reg;
        s6_hi_reg   <= s5_hi_reg;
        s6_sat_reg  <= s5_sat_reg;
        s6_axes_reg <= s5_axes_reg;
    end

    // stage 7: normalizing shift
    logic [RAD_W-1:0] wide7 [4];

    logic                     s7_valid_reg;
    logic [NRM_W-1:0]         s7_m_reg [4];
    logic [1:0]               s7_zero_reg;
    logic [3:0]               s7_neg_reg;
    logic signed [DATA_W-1:0] s7_lo_reg;
    logic signed [DATA_W-1:0] s7_hi_reg;
    logic                     s7_sat_reg;
    logic                     s7_axes_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (s6_msb_reg[i/2] >= 6'd30)
                wide7[i] = RAD_W'(s6_mag_reg[i]) >> (s6_msb_reg[i/2] - 6'd30);
            else
                wide7[i] = RAD_W'(s6_mag_reg[i]) << (6'd30 - s6_msb_reg[i/2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            s7_m_reg[i] <= wide7[i][NRM_W-1:0];
        s7_zero_reg <= s6_zero_reg;
        s7_neg_reg  <= s6_neg_reg;
        s7_lo_reg   <= s6_lo_reg;
        s7_hi_reg   <= s6_hi_reg;
        s7_sat_reg  <= s6_sat_reg;
        s7_axes_reg <= s6_axes_reg;
    end

    // stage 8: squares
    logic                     s8_valid_reg;
    logic [2*NRM_W-1:0]       s8_pr_reg [4];
    logic [NRM_W-1:0]         s8_m_reg [4];
    logic [1:0]               s8_zero_reg;
    logic [3:0]               s8_neg_reg;
    logic signed [DATA_W-1:0] s8_lo_reg;
    logic signed [DATA_W-1:0] s8_hi_reg;
    logic                     s8_sat_reg;
    logic                     s8_axes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            s8_pr_reg[i] <= (2*NRM_W)'(s7_m_reg[i]) * (2*NRM_W)'(s7_m_reg[i]);
        s8_m_reg    <= s7_m_reg;
        s8_zero_reg <= s7_zero_reg;
        s8_neg_reg  <= s7_neg_reg;
        s8_lo_reg   <= s7_lo_reg;
        s8_hi_reg   <= s7_hi_reg;
        s8_sat_reg  <= s7_sat_reg;
        s8_axes_reg <= s7_axes_reg;
    end

    // stage 9: squared norms
    logic                  s9_valid_reg;
    logic [RAD_W-1:0]      s9_s_reg [2];
    eig_norm_side_t        s9_side_reg;
    logic [1:0][RAD_W-1:0] rad_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_valid_reg <= 1'b0;
        else
            s9_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
            s9_s_reg[v] <= RAD_W'(s8_pr_reg[2*v]) + RAD_W'(s8_pr_reg[2*v+1]);
        for (int i = 0; i < 4; i++)
            s9_side_reg.mag[i] <= s8_m_reg[i];
        s9_side_reg.zero <= s8_zero_reg;
        s9_side_reg.neg  <= s8_neg_reg;
        s9_side_reg.lo   <= s8_lo_reg;
        s9_side_reg.hi   <= s8_hi_reg;
        s9_side_reg.sat  <= s8_sat_reg;
        s9_side_reg.axes <= s8_axes_reg;
    end

    assign rad_b[0] = s9_s_reg[0];
    assign rad_b[1] = s9_s_reg[1];

    logic                   sb_valid;
    logic [1:0][ROOT_W-1:0] norm_b;
    eig_norm_side_t         sb_side;

    eig2x2_sqrt_pipe #(
        .IW    (RAD_W),
        .LANES (2),
        .PW    ($bits(eig_norm_side_t))
    ) u_norm_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s9_valid_reg),
        .in_rad    (rad_b),
        .in_side   (s9_side_reg),
        .out_valid (sb_valid),
        .out_root  (norm_b),
        .out_side  (sb_side)
    );

    // stage 10: dividend and divisor
    logic                  s10_valid_reg;
    logic [3:0][NUM_W-1:0] s10_num_reg;
    logic [3:0][DEN_W-1:0] s10_den_reg;
    eig_div_side_t         s10_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_valid_reg <= 1'b0;
        else
            s10_valid_reg <= sb_valid;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            s10_num_reg[i] <= NUM_W'({sb_side.mag[i], 30'b0}) + NUM_W'(norm_b[i/2] >> 1);
            s10_den_reg[i] <= norm_b[i/2];
        end
        s10_side_reg.lo   <= sb_side.lo;
        s10_side_reg.hi   <= sb_side.hi;
        s10_side_reg.sat  <= sb_side.sat;
        s10_side_reg.axes <= sb_side.axes;
        s10_side_reg.zero <= sb_side.zero;
        s10_side_reg.neg  <= sb_side.neg;
    end

    logic                  dv_valid;
    logic [3:0][QUO_W-1:0] quo_d;
    eig_div_side_t         dv_side;

    eig2x2_div_pipe #(
        .NW    (NUM_W),
        .DW    (DEN_W),
        .QW    (QUO_W),
        .LANES (4),
        .PW    ($bits(eig_div_side_t))
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s10_valid_reg),
        .in_num    (s10_num_reg),
        .in_den    (s10_den_reg),
        .in_side   (s10_side_reg),
        .out_valid (dv_valid),
        .out_quo   (quo_d),
        .out_side  (dv_side)
    );

    // complex flag rides a delay line beside the pipeline
    logic [LAT-5:0] cplx_line_reg;
    logic           complex_flag_d;

    always_ff @(posedge clk)
    begin
        cplx_line_reg <= {cplx_line_reg[LAT-6:0], s3_side_reg.cplx};
    end

    assign complex_flag_d = cplx_line_reg[LAT-5];

    // output stage
    logic [DATA_W-1:0] vec11 [4];
    logic [DATA_W-1:0] qx;

    always_comb
    begin
        qx = '0;
        for (int i = 0; i < 4; i++)
        begin
            qx       = DATA_W'(quo_d[i]);
            vec11[i] = dv_side.neg[i] ? DATA_W'(-qx) : qx;
        end
        if (dv_side.axes || dv_side.zero[0])
        begin
            vec11[0] = Q_ONE;
            vec11[1] = '0;
        end
        if (dv_side.axes || dv_side.zero[1])
        begin
            vec11[2] = '0;
            vec11[3] = Q_ONE;
        end
    end

    logic                     done_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0]        vec_reg [4];
    logic                     cplx_reg;
    logic                     sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= dv_side.lo;
        hi_reg   <= dv_side.hi;
        vec_reg  <= vec11;
        cplx_reg <= dv_side.axes && (dv_side.lo == dv_side.hi) && !dv_side.sat
                    && complex_flag_d;
        sat_reg  <= dv_side.sat;
    end

    assign done             = done_reg;
    assign small_eigenvalue = lo_reg;
    assign large_eigenvalue = hi_reg;
    assign first_vec_x      = vec_reg[0];
    assign first_vec_y      = vec_reg[1];
    assign second_vec_x     = vec_reg[2];
    assign second_vec_y     = vec_reg[3];
    assign complex_roots    = cplx_reg;
    assign saturated        = sat_reg;

`ifndef NO_ASSERTIONS
    ap_cplx_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && complex_roots |-> !saturated)
        else $error("complex item flagged as saturated");

    ap_cplx_equal: assert property (@(posedge clk) disable iff (!rst_n)
        done && complex_roots |-> small_eigenvalue == large_eigenvalue)
        else $error("complex item with unequal eigenvalues");

    ap_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> small_eigenvalue <= large_eigenvalue)
        else $error("eigenvalues out of order");

    ap_cplx_axes: assert property (@(posedge clk) disable iff (!rst_n)
        done && complex_roots |-> first_vec_x == Q_ONE && first_vec_y == '0)
        else $error("complex item without axis vectors");

    ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching item");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for eigen_decomposition_2x2_unit: drives 2x2 matrices,
// predicts eigenvalues and unit eigenvectors in exact integer arithmetic and checks each result.
// Depends on eig2x2_pkg and the eigen_decomposition_2x2_unit RTL.
`timescale 1ns / 100ps

module tb_top;
    import eig2x2_pkg::*;

    localparam int LATENCY     = 106;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] v0x;
        logic signed [DATA_W-1:0] v0y;
        logic signed [DATA_W-1:0] v1x;
        logic signed [DATA_W-1:0] v1y;
        logic                     cplx;
        logic                     sat;
    } eig_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tolerance_we = 1'b0;
    logic [TOL_W-1:0] tolerance_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [DATA_W-1:0] top_left = '0, top_right = '0, bottom_left = '0, bottom_right = '0;
    logic done;
    logic signed [DATA_W-1:0] small_eigenvalue, large_eigenvalue;
    logic signed [DATA_W-1:0] first_vec_x, first_vec_y, second_vec_x, second_vec_y;
    logic complex_roots, saturated;

    eig_result_t expected_q[$];
    logic [TOL_W-1:0] tol_shadow = '0;
    int unsigned send_idle_pct = 0;
    int errors = 0;
    longint cycles = 0;

    eigen_decomposition_2x2_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .tolerance_we(tolerance_we), .tolerance_wdata(tolerance_wdata),
        .start(start), .busy(busy),
        .top_left(top_left), .top_right(top_right),
        .bottom_left(bottom_left), .bottom_right(bottom_right),
        .done(done),
        .small_eigenvalue(small_eigenvalue), .large_eigenvalue(large_eigenvalue),
        .first_vec_x(first_vec_x), .first_vec_y(first_vec_y),
        .second_vec_x(second_vec_x), .second_vec_y(second_vec_y),
        .complex_roots(complex_roots), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_vector(longint x, longint y, longint ax, longint ay,
                                        output longint ox, output longint oy);
        logic [63:0] mx, my, big, n, r;
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        big = (mx > my) ? mx : my;
        if (big == 0)
        begin
            ox = ax;
            oy = ay;
            return;
        end
        while (big >= (64'd1 << 31))
        begin
            mx >>= 1; my >>= 1; big >>= 1;
        end
        while (big < (64'd1 << 30))
        begin
            mx <<= 1; my <<= 1; big <<= 1;
        end
        n = int_sqrt(mx * mx + my * my);
        r = ((mx << 30) + n / 2) / n;
        ox = (x < 0) ? -longint'(r) : longint'(r);
        r = ((my << 30) + n / 2) / n;
        oy = (y < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_q16(longint v, ref logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic eig_result_t predict_eigen(longint a, longint b, longint c, longint d);
        eig_result_t res;
        longint t, h, disc, lo, hi, root, v0x, v0y, v1x, v1y;
        logic [63:0] sq, mb, mc, mmax;
        logic sat;
        t = a + d;
        h = (t >= 0) ? t / 2 : -((-t + 1) / 2);
        sq = (a - d < 0) ? -(a - d) : (a - d);
        sq = sq * sq;
        disc = longint'(sq >> 2) + b * c;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        mmax = (mb > mc) ? mb : mc;
        sat = 1'b0;
        v0x = Q_ONE; v0y = 0; v1x = 0; v1y = Q_ONE;
        res.cplx = (disc < 0);
        if (disc < 0)
        begin
            lo = h;
            hi = h;
        end
        else
        begin
            root = longint'(int_sqrt(disc));
            lo = clamp_q16(h - root, sat);
            hi = clamp_q16(h + root, sat);
            if (mmax > tol_shadow)
            begin
                if (mb > mc)
                begin
                    unit_vector(b, lo - a, Q_ONE, 0, v0x, v0y);
                    unit_vector(b, hi - a, 0, Q_ONE, v1x, v1y);
                end
                else
                begin
                    unit_vector(lo - d, c, Q_ONE, 0, v0x, v0y);
                    unit_vector(hi - d, c, 0, Q_ONE, v1x, v1y);
                end
            end
        end
        res.lo = lo[31:0];
        res.hi = hi[31:0];
        res.v0x = v0x[31:0];
        res.v0y = v0y[31:0];
        res.v1x = v1x[31:0];
        res.v1y = v1y[31:0];
        res.sat = sat;
        return res;
    endfunction

    task automatic send_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        top_left <= a;
        top_right <= b;
        bottom_left <= c;
        bottom_right <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(predict_eigen(longint'(signed'(a)), longint'(signed'(b)),
                                           longint'(signed'(c)), longint'(signed'(d))));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        drain_results();
        tolerance_we <= 1'b1;
        tolerance_wdata <= value;
        @(posedge clk);
        tolerance_we <= 1'b0;
        tol_shadow = value;
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(2 * 65536 * 16)) - 65536 * 16);
            2: return 32'(signed'($urandom_range(2 * 256)) - 256);
            3: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
            4: return 32'($urandom) >>> $urandom_range(31);
            default: return 32'(signed'($urandom_range(2 * 65536 * 1024)) - 65536 * 1024);
        endcase
    endfunction

    task automatic test_directed();
        send_matrix(32'h0, 32'h0, 32'h0, 32'h0);
        send_matrix(32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000);
        send_matrix(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
        send_matrix(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000);
        send_matrix(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_matrix(32'h0, 32'h0001_0000, 32'hffff_0000, 32'h0);
        send_matrix(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
        send_matrix(32'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff);
        send_matrix(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000);
        send_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_matrix(32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000);
        send_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_matrix(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_matrix(32'h0, 32'h0000_0001, 32'h0000_0001, 32'h0);
        send_matrix(32'h0003_0000, 32'hfffe_0000, 32'h0002_0000, 32'h0001_0000);
        send_matrix(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry());
    endtask

    task automatic test_tolerance();
        write_tolerance('1);
        test_random(60);
        write_tolerance(31'h0001_0000);
        send_matrix(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0002_0000);
        send_matrix(32'h0001_0000, 32'h0001_0001, 32'h0, 32'h0002_0000);
        test_random(60);
        write_tolerance(31'($urandom));
        test_random(60);
        write_tolerance('0);
    endtask

    always @(posedge clk)
    begin
        eig_result_t exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL eigen_decomposition_2x2_unit");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (small_eigenvalue !== exp_r.lo)
                begin
                    $error("small_eigenvalue exp %h got %h", exp_r.lo, small_eigenvalue);
                    errors++;
                end
                if (large_eigenvalue !== exp_r.hi)
                begin
                    $error("large_eigenvalue exp %h got %h", exp_r.hi, large_eigenvalue);
                    errors++;
                end
                if (first_vec_x !== exp_r.v0x)
                begin
                    $error("first_vec_x exp %h got %h", exp_r.v0x, first_vec_x);
                    errors++;
                end
                if (first_vec_y !== exp_r.v0y)
                begin
                    $error("first_vec_y exp %h got %h", exp_r.v0y, first_vec_y);
                    errors++;
                end
                if (second_vec_x !== exp_r.v1x)
                begin
                    $error("second_vec_x exp %h got %h", exp_r.v1x, second_vec_x);
                    errors++;
                end
                if (second_vec_y !== exp_r.v1y)
                begin
                    $error("second_vec_y exp %h got %h", exp_r.v1y, second_vec_y);
                    errors++;
                end
                if (complex_roots !== exp_r.cplx)
                begin
                    $error("complex_roots exp %b got %b", exp_r.cplx, complex_roots);
                    errors++;
                end
                if (saturated !== exp_r.sat)
                begin
                    $error("saturated exp %b got %b", exp_r.sat, saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 35;
        test_directed();
        test_random(250);
        drain_results();
        send_idle_pct = 61;
        test_random(250);
        test_tolerance();
        send_idle_pct = 0;
        test_random(320);
        drain_results();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS eigen_decomposition_2x2_unit");
        else
            $display("FAIL eigen_decomposition_2x2_unit");
        $finish;
    end

endmodule
